>>> rtl/first_fit_max_tree_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_MAX_TREE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_MAX_TREE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FFMT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define FFMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ffmt_pkg.sv
// Package: constants, payload structs and shared types for the first-fit allocator.
package ffmt_pkg;

	localparam int LEAF_COUNT  = 1024;
	localparam int LEAF_W      = $clog2(LEAF_COUNT);
	localparam int NODE_W      = LEAF_W + 1;
	localparam int NODE_COUNT  = 2 * LEAF_COUNT;
	localparam int VALUE_WIDTH = 32;
	localparam int BIN_W       = 11;
	localparam int AMOUNT_W    = 32;
	localparam int HOTEL_W     = 11;
	localparam logic [HOTEL_W-1:0] HOTEL_RESET = HOTEL_W'(1024);

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef logic [NODE_W-1:0]      node_t;
	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		logic                req_type;
		logic [BIN_W-1:0]    bin_index;
		logic [AMOUNT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [BIN_W-1:0] chosen_bin;
	} rsp_t;

	// result of the shared compare unit
	typedef struct packed {
		logic   lt;
		value_t maxv;
	} cmp_res_t;

endpackage

>>> rtl/ffmt_ram.sv
// Tree node memory: one write port, one read port with registered read data.
module ffmt_ram (
	input  logic            clk,
	input  logic            wr_en,
	input  ffmt_pkg::node_t  wr_addr,
	input  ffmt_pkg::value_t wr_data,
	input  logic            rd_en,
	input  ffmt_pkg::node_t  rd_addr,
	output ffmt_pkg::value_t rd_data
);

	ffmt_pkg::value_t mem [ffmt_pkg::NODE_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/ffmt_cmp_unit.sv
// Shared compare unit: less-than test and maximum of two node values.
module ffmt_cmp_unit (
	input  ffmt_pkg::value_t   a,
	input  ffmt_pkg::value_t   b,
	output ffmt_pkg::cmp_res_t res
);

	always_comb begin
		res.lt   = a < b;
		res.maxv = res.lt ? b : a;
	end

endmodule

>>> rtl/first_fit_max_tree_allocator.sv
// A query passes root read, one descent level a cycle, leaf update, one ancestor a cycle up and
// the result register; a load climbs from its leaf to the root and gives no result.
// An out-of-range load is dropped in S_IDLE, a no-fit query ends its search at the root, and a
// held result waits on rsp_ready before the next item is taken.
// One item at a time; the one tree memory (a read and a write a cycle) sets the pace.
// Reset: arst_n zeroes the tree one node a cycle, req_ready low meanwhile.
module first_fit_max_tree_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ffmt_pkg::HOTEL_W-1:0]        cfg_data,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  ffmt_pkg::req_t                     req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output ffmt_pkg::rsp_t                     rsp
);

	`include "first_fit_max_tree_allocator_assert.svh"

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_ROOT   = 7'b0000100,
		S_DESC   = 7'b0001000,
		S_LEAF   = 7'b0010000,
		S_CLIMB  = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t                        state_q, state_d;
	ffmt_pkg::node_t               node_q, node_d;
	ffmt_pkg::node_t               clr_q, clr_d;
	ffmt_pkg::value_t              cur_q, cur_d;
	ffmt_pkg::value_t              amt_q;
	logic                          query_q;
	ffmt_pkg::rsp_t                res_q, res_d;
	logic [ffmt_pkg::HOTEL_W-1:0]  hotel_q;
	logic                          rsp_valid_q;
	ffmt_pkg::rsp_t                rsp_q;

	logic                          wr_en, rd_en;
	ffmt_pkg::node_t               wr_addr, rd_addr;
	ffmt_pkg::value_t              wr_data, rd_data;
	ffmt_pkg::value_t              cmp_a, cmp_b;
	ffmt_pkg::cmp_res_t            cmp;
	ffmt_pkg::node_t               child, parent;
	logic                          accept, load_ok, rsp_load;

	ffmt_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ffmt_cmp_unit u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == S_FINISH) && (!rsp_valid_q || rsp_ready);

	assign load_ok = (req.bin_index != '0) && (req.bin_index <= hotel_q)
		&& ((ffmt_pkg::BIN_W+1)'(req.bin_index) <= (ffmt_pkg::BIN_W+1)'(ffmt_pkg::LEAF_COUNT));

	// climbing: max of held value and sibling; otherwise memory value against request
	assign cmp_a = (state_q == S_CLIMB) ? cur_q : rd_data;
	assign cmp_b = (state_q == S_CLIMB) ? rd_data : amt_q;

	// right child when the left one is too small
	assign child  = {node_q[ffmt_pkg::NODE_W-2:0], cmp.lt};
	assign parent = node_q >> 1;

	always_comb begin
		state_d = state_q;
		node_d  = node_q;
		clr_d   = clr_q;
		cur_d   = cur_q;
		res_d   = res_q;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = cur_q;
		rd_en   = 1'b0;
		rd_addr = node_q ^ ffmt_pkg::NODE_W'(1);
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				clr_d   = clr_q + ffmt_pkg::NODE_W'(1);
				if (clr_q == ffmt_pkg::NODE_W'(ffmt_pkg::NODE_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req.req_type == ffmt_pkg::REQ_QUERY) begin
						rd_en   = 1'b1;
						rd_addr = ffmt_pkg::NODE_W'(1);
						state_d = S_ROOT;
					end else if (load_ok) begin
						node_d  = ffmt_pkg::NODE_W'(ffmt_pkg::LEAF_COUNT)
							+ ffmt_pkg::NODE_W'(req.bin_index) - ffmt_pkg::NODE_W'(1);
						cur_d   = ffmt_pkg::VALUE_WIDTH'(req.amount);
						wr_en   = 1'b1;
						wr_addr = node_d;
						wr_data = cur_d;
						rd_en   = 1'b1;
						rd_addr = node_d ^ ffmt_pkg::NODE_W'(1);
						state_d = S_CLIMB;
					end
				end
			end
			S_ROOT: begin
				if (cmp.lt) begin
					res_d   = '0;
					state_d = S_FINISH;
				end else begin
					cur_d   = rd_data;
					node_d  = ffmt_pkg::NODE_W'(1);
					rd_en   = 1'b1;
					rd_addr = ffmt_pkg::NODE_W'(2);
					state_d = S_DESC;
				end
			end
			S_DESC: begin
				// parent >= request and left < request means right equals parent
				node_d = child;
				if (!cmp.lt) begin
					cur_d = rd_data;
				end
				if (child[ffmt_pkg::NODE_W-1]) begin
					state_d = S_LEAF;
				end else begin
					rd_en   = 1'b1;
					rd_addr = {child[ffmt_pkg::NODE_W-2:0], 1'b0};
				end
			end
			S_LEAF: begin
				cur_d   = cur_q - amt_q;
				wr_en   = 1'b1;
				wr_data = cur_d;
				rd_en   = 1'b1;
				res_d.found      = 1'b1;
				res_d.chosen_bin = ffmt_pkg::BIN_W'(node_q[ffmt_pkg::LEAF_W-1:0])
					+ ffmt_pkg::BIN_W'(1);
				state_d = S_CLIMB;
			end
			S_CLIMB: begin
				wr_en   = 1'b1;
				wr_addr = parent;
				wr_data = cmp.maxv;
				node_d  = parent;
				cur_d   = cmp.maxv;
				if (parent == ffmt_pkg::NODE_W'(1)) begin
					state_d = query_q ? S_FINISH : S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = parent ^ ffmt_pkg::NODE_W'(1);
				end
			end
			S_FINISH: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			hotel_q     <= ffmt_pkg::HOTEL_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (cfg_valid && cfg_ready) begin
				hotel_q <= cfg_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		cur_q  <= cur_d;
		res_q  <= res_d;
		if (accept) begin
			amt_q   <= ffmt_pkg::VALUE_WIDTH'(req.amount);
			query_q <= req.req_type;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	`FFMT_ASSERT_NOW(a_desc_inner, state_q == S_DESC,
		!node_q[ffmt_pkg::NODE_W-1], "descent walked past the leaf level")
	`FFMT_ASSERT_NOW(a_leaf_fits, state_q == S_LEAF, cur_q >= amt_q,
		"chosen bin is smaller than the request")
	`FFMT_ASSERT_NEXT(a_root_miss, (state_q == S_ROOT) && cmp.lt,
		(state_q == S_FINISH) && !res_q.found, "root miss did not report no fit")
	`FFMT_ASSERT_NOW(a_res_consistent, state_q == S_FINISH,
		res_q.found == (res_q.chosen_bin != '0), "found flag disagrees with bin index")

endmodule

>>> tb/sv/first_fit_max_tree_allocator_test.sv
// Self-checking testbench for the first-fit max-tree bin allocator.
module first_fit_max_tree_allocator_test;
	import ffmt_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int SETTLE_CYCLES   = 40;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int PHASES          = 6;
	localparam int PHASE_ITEMS     = 210;

	// Tracks free capacity per bin and the allocation each query should make
	class bin_alloc_scoreboard;
		value_t               free_cap[NODE_COUNT];
		logic [HOTEL_W-1:0]   hotel;
		rsp_t                 expected_bins[$];
		int                   mismatch_count;

		function new();
			foreach (free_cap[i]) free_cap[i] = '0;
			hotel = HOTEL_RESET;
			mismatch_count = 0;
		endfunction

		function void set_hotel(logic [HOTEL_W-1:0] v);
			hotel = v;
		endfunction

		function value_t root();
			return free_cap[1];
		endfunction

		function int pending();
			return expected_bins.size();
		endfunction

		function void refresh_path(int unsigned node);
			int unsigned k;
			k = node >> 1;
			while (k != 0) begin
				free_cap[k] = (free_cap[2*k] > free_cap[2*k+1]) ? free_cap[2*k] : free_cap[2*k+1];
				k = k >> 1;
			end
		endfunction

		function void note_request(req_t r);
			int unsigned node;
			value_t      amt;
			rsp_t        alloc;
			amt = r.amount;
			if (r.req_type == REQ_LOAD) begin
				if (r.bin_index >= 1 && r.bin_index <= hotel && r.bin_index <= LEAF_COUNT) begin
					node = LEAF_COUNT + r.bin_index - 1;
					free_cap[node] = amt;
					refresh_path(node);
				end
				return;
			end
			alloc = '0;
			if (free_cap[1] >= amt) begin
				// leftmost leaf that can take the request
				node = 1;
				while (node < LEAF_COUNT) begin
					node = 2 * node;
					if (free_cap[node] < amt)
						node++;
				end
				free_cap[node] = free_cap[node] - amt;
				refresh_path(node);
				alloc.found = 1'b1;
				alloc.chosen_bin = BIN_W'(node - LEAF_COUNT + 1);
			end
			expected_bins.push_back(alloc);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_bins.size() == 0) begin
				$display("%0t: result with nothing outstanding: found=%0b chosen_bin=%0d",
					$time, got.found, got.chosen_bin);
				mismatch_count++;
				return;
			end
			want = expected_bins.pop_front();
			if (got.found !== want.found) begin
				$display("%0t: found mismatch, expected %0b, actual %0b",
					$time, want.found, got.found);
				mismatch_count++;
			end
			if (got.chosen_bin !== want.chosen_bin) begin
				$display("%0t: chosen_bin mismatch, expected %0d, actual %0d",
					$time, want.chosen_bin, got.chosen_bin);
				mismatch_count++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [HOTEL_W-1:0]   cfg_data;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;

	bin_alloc_scoreboard  sb = new();
	bit                   hold_off_req = 1'b0;
	bit                   rsp_stalls_on = 1'b1;
	int                   idle_cycles = 0;

	first_fit_max_tree_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #CLK_HALF clk = ~clk;

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
			if (req_valid && req_ready)
				sb.note_request(req);
			if (cfg_valid && cfg_ready)
				sb.set_hotel(cfg_data);
			if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : rsp_side
		rsp_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(negedge clk);
			end
		end
	end

	function automatic req_t make_random_req();
		req_t        r;
		int unsigned span;
		value_t      top;
		span = (sb.hotel == 0) ? 1 : ((sb.hotel > LEAF_COUNT) ? LEAF_COUNT : sb.hotel);
		top = sb.root();
		r.bin_index = BIN_W'($urandom_range(0, 2047));
		r.amount = $urandom();
		if ($urandom_range(0, 99) < 45) begin
			r.req_type = REQ_LOAD;
			if ($urandom_range(0, 6) != 0)
				r.bin_index = BIN_W'($urandom_range(1, span));
			case ($urandom_range(0, 9))
				0: r.amount = '0;
				1: r.amount = '1;
				2, 3, 4: ;
				default: r.amount = $urandom_range(0, 255);
			endcase
		end else begin
			r.req_type = REQ_QUERY;
			case ($urandom_range(0, 19))
				0: r.amount = '0;
				1: r.amount = '1;
				2, 3, 4: r.amount = top;
				5, 6: r.amount = (top == '1) ? top : top + 1;
				7, 8, 9: r.amount = $urandom_range(0, top);
				10, 11: ;
				default: r.amount = $urandom_range(0, 63);
			endcase
		end
		return r;
	endfunction

	// offer one item from the falling edge and hold it until its transfer
	task automatic send_req(input req_t item, input bit fresh);
		@(negedge clk);
		if (fresh)
			item = make_random_req();
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic req_idle(input int unsigned n);
		@(negedge clk);
		req_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		req_idle(1);
		while (sb.pending() != 0) @(posedge clk);
		// a trailing load gives no result but may still be walking the tree
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_hotel(input logic [HOTEL_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [HOTEL_W-1:0] plan[PHASES];
		int unsigned        phase;
		int unsigned        n;
		bit                 last_phase;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		plan[0] = HOTEL_RESET;
		plan[1] = HOTEL_W'(16);
		plan[2] = HOTEL_W'(1);
		plan[3] = HOTEL_W'($urandom_range(2, 1023));
		plan[4] = '1;
		plan[5] = HOTEL_RESET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		write_hotel(HOTEL_RESET);
		// empty tree: zero request fits bin 1, anything else misses
		send_req('{REQ_QUERY, BIN_W'(0), 32'h0}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(2047), 32'h1}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(0), 32'hFFFF_FFFF}, 1'b0);
		// out-of-range loads are dropped, then in-range loads and queries follow
		send_req('{REQ_LOAD, BIN_W'(0), 32'd100}, 1'b0);
		send_req('{REQ_LOAD, BIN_W'(1025), 32'd5}, 1'b0);
		send_req('{REQ_LOAD, BIN_W'(2047), 32'd7}, 1'b0);
		send_req('{REQ_LOAD, BIN_W'(1024), 32'hFFFF_FFFF}, 1'b0);
		send_req('{REQ_LOAD, BIN_W'(1), 32'd10}, 1'b0);
		send_req('{REQ_LOAD, BIN_W'(512), 32'h8000_0000}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(0), 32'd10}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(0), 32'd0}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(0), 32'd11}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(0), 32'hFFFF_FFFF}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(0), 32'h7FFF_FFF5}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(0), 32'd1}, 1'b0);
		send_req('{REQ_LOAD, BIN_W'(2), 32'hAAAA_AAAA}, 1'b0);
		send_req('{REQ_LOAD, BIN_W'(3), 32'h5555_5555}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(1365), 32'h5555_5555}, 1'b0);
		// one bin in use; bins loaded earlier stay searchable
		write_hotel(HOTEL_W'(1));
		send_req('{REQ_LOAD, BIN_W'(2), 32'd9}, 1'b0);
		send_req('{REQ_LOAD, BIN_W'(1), 32'd9}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(0), 32'd9}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(0), 32'h5555_5555}, 1'b0);
		write_hotel(HOTEL_W'(0));
		send_req('{REQ_LOAD, BIN_W'(1), 32'd3}, 1'b0);
		send_req('{REQ_QUERY, BIN_W'(0), 32'd1}, 1'b0);

		for (phase = 0; phase < PHASES; phase++) begin
			last_phase = (phase == PHASES - 1);
			rsp_stalls_on = !last_phase;
			write_hotel(plan[phase]);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 1 && n == 20)
					hold_off_req = 1'b1;
				if (!last_phase && $urandom_range(0, 5) == 0)
					req_idle($urandom_range(1, 15));
				send_req('0, 1'b1);
			end
		end

		drain();
		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
